/* src/chbe_pkg.sv */
// Shared types, request codes and defaults for the canonical Huffman byte encoder.
`timescale 1ns / 1ps
package chbe_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    // Field widths of the input and output items
    localparam int REQ_W  = 2;
    localparam int SYM_W  = 8;
    localparam int CLEN_W = 6;
    localparam int BYTE_W = 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_PAD  = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SYM_W-1:0]  symbol;
        logic [CLEN_W-1:0] sym_len;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_kind;
        logic              last;
    } t_out_item;

    // Control handed from the table stage to the packer
    typedef struct packed {
        logic vld;
        logic flush;
    } t_pk_ctl;

endpackage

/* src/chbe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module chbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/chbe_table.sv */
// Code table front end: accepts items, assigns canonical codes, looks up codes.
`timescale 1ns / 1ps
module chbe_table #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  chbe_pkg::t_in_item                 i_item,
    input  logic                               i_take,
    output logic                               o_stall,
    output chbe_pkg::t_pk_ctl                  o_ctl,
    output logic [MAX_CODE_LEN-1:0]            o_code,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]  o_len
);
    import chbe_pkg::*;

    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int EW = LW + MAX_CODE_LEN;
    localparam int CW = CLEN_W + 1;

    logic [MAX_CODE_LEN-1:0] r_nc, n_nc;
    logic [LW-1:0]           r_cur, n_cur;
    logic [SYMBOL_COUNT-1:0] r_valid, n_valid;
    logic                    r_s1_vld, n_s1_vld;
    logic                    r_s1_flush, n_s1_flush;

    logic                    accept;
    logic                    sym_ok;
    logic [AW-1:0]           addr;
    logic [CW-1:0]           len_x;
    logic [CW-1:0]           cur_x;
    logic [CW-1:0]           shift;
    logic [MAX_CODE_LEN-1:0] shifted;
    logic [MAX_CODE_LEN-1:0] mask;
    logic                    load_ok;
    logic                    enc_ok;
    logic                    ram_we;
    logic                    ram_re;
    logic [EW-1:0]           ram_wdata;
    logic [EW-1:0]           ram_rdata;

    // Hold the input while the lookup stage is full and the packer is busy
    assign o_stall = r_s1_vld && !i_take;
    assign accept  = i_valid && !o_stall;

    // Decode the item
    assign sym_ok  = {1'b0, i_item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign addr    = i_item.symbol[AW-1:0];
    assign len_x   = {1'b0, i_item.sym_len};
    assign cur_x   = CW'(r_cur);
    assign load_ok = (len_x != '0) && (len_x <= CW'(MAX_CODE_LEN)) && (len_x >= cur_x)
                     && sym_ok;
    assign enc_ok  = sym_ok && r_valid[addr];

    // Canonical code: shift on length growth, keep the low len bits
    assign shift     = len_x - cur_x;
    assign shifted   = r_nc << shift;
    assign mask      = ~({MAX_CODE_LEN{1'b1}} << len_x);
    assign ram_wdata = {LW'(len_x), shifted & mask};

    assign ram_we = accept && (i_item.req_type == REQ_LOAD) && load_ok;
    assign ram_re = accept && (i_item.req_type == REQ_ENCODE) && enc_ok;

    chbe_ram #(
        .WIDTH (EW),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    // Update table registers and the lookup stage
    always_comb begin
        n_nc       = r_nc;
        n_cur      = r_cur;
        n_valid    = r_valid;
        n_s1_vld   = r_s1_vld;
        n_s1_flush = r_s1_flush;
        if (i_take) begin
            n_s1_vld = 1'b0;
        end
        if (accept) begin
            case (i_item.req_type)
                REQ_LOAD: begin
                    if (load_ok) begin
                        n_nc          = shifted + MAX_CODE_LEN'(1);
                        n_cur         = LW'(len_x);
                        n_valid[addr] = 1'b1;
                    end
                end
                REQ_ENCODE: begin
                    n_s1_vld   = enc_ok;
                    n_s1_flush = 1'b0;
                end
                REQ_FLUSH: begin
                    n_s1_vld   = 1'b1;
                    n_s1_flush = 1'b1;
                end
                REQ_CLEAR: begin
                    n_nc    = '0;
                    n_cur   = '0;
                    n_valid = '0;
                end
                default: begin
                    n_s1_vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc       <= '0;
            r_cur      <= '0;
            r_valid    <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            r_nc       <= n_nc;
            r_cur      <= n_cur;
            r_valid    <= n_valid;
            r_s1_vld   <= n_s1_vld;
            r_s1_flush <= n_s1_flush;
        end
    end

    assign o_ctl.vld   = r_s1_vld;
    assign o_ctl.flush = r_s1_flush;
    assign o_code      = ram_rdata[MAX_CODE_LEN-1:0];
    assign o_len       = ram_rdata[EW-1:MAX_CODE_LEN];

endmodule

/* src/chbe_packer.sv */
// Bit packer: appends codes MSB first and emits bytes through an output register.
`timescale 1ns / 1ps
module chbe_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  chbe_pkg::t_pk_ctl                  i_ctl,
    input  logic [MAX_CODE_LEN-1:0]            i_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  i_len,
    output logic                               o_idle,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output chbe_pkg::t_out_item                o_out_item
);
    import chbe_pkg::*;

    localparam int BUF_W = MAX_CODE_LEN + BYTE_W;
    localparam int CW    = $clog2(BUF_W + 1);

    logic [BUF_W-1:0] r_buf, n_buf;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_fl, n_fl;
    logic [3:0]       r_pad, n_pad;
    logic             r_ov, n_ov;
    t_out_item        r_out, n_out;

    logic             out_free;
    logic             take;
    logic [CW-1:0]    sh;
    logic [BUF_W-1:0] code_x;

    // Idle once no full byte and no flush is pending
    assign o_idle   = !r_fl && (r_cnt < CW'(BYTE_W));
    assign out_free = !r_ov || !i_out_stall;
    assign take     = i_ctl.vld && o_idle;

    // Left-aligned buffer: place the new code right below the pending bits
    assign sh     = CW'(BUF_W) - r_cnt - CW'(i_len);
    assign code_x = {{BYTE_W{1'b0}}, i_code};

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        n_fl  = r_fl;
        n_pad = r_pad;
        n_ov  = r_ov;
        n_out = r_out;
        if (out_free) begin
            n_ov = 1'b0;
        end
        if (take) begin
            if (i_ctl.flush) begin
                // Pad the partial byte by promoting it to a full one
                n_pad = 4'd8 - {1'b0, r_cnt[2:0]};
                n_fl  = 1'b1;
                if (r_cnt != '0) begin
                    n_cnt = CW'(BYTE_W);
                end
            end else begin
                n_buf = r_buf | (code_x << sh);
                n_cnt = r_cnt + CW'(i_len);
            end
        end else if ((r_cnt >= CW'(BYTE_W)) && out_free) begin
            // Emit the top byte
            n_ov            = 1'b1;
            n_out.out_byte  = r_buf[BUF_W-1 -: BYTE_W];
            n_out.byte_kind = KIND_DATA;
            n_out.last      = !r_fl && ((r_cnt - CW'(BYTE_W)) < CW'(BYTE_W));
            n_buf           = r_buf << BYTE_W;
            n_cnt           = r_cnt - CW'(BYTE_W);
        end else if (r_fl && out_free) begin
            // Emit the padding count and drop the buffer
            n_ov            = 1'b1;
            n_out.out_byte  = {4'd0, r_pad};
            n_out.byte_kind = KIND_PAD;
            n_out.last      = 1'b1;
            n_fl            = 1'b0;
            n_buf           = '0;
            n_cnt           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
            r_fl  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
            r_fl  <= n_fl;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad <= n_pad;
        r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

/* src/canonical_huffman_byte_encoder.sv */
// An encode or flush item passes the lookup stage, the packer's bit buffer and the output
// register before its first byte shows. The table stage takes one item per cycle unless the
// packer is busy; the packer takes no new item while a full byte or a flush is pending.
// Loads and clears produce no bytes.
// Reset (synchronous, active low) clears valid bits, running code and bit buffer;
// the code memory itself is not cleared.
`timescale 1ns / 1ps
module canonical_huffman_byte_encoder #(
    parameter int MAX_CODE_LEN = chbe_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = chbe_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  chbe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output chbe_pkg::t_out_item o_out_item
);
    import chbe_pkg::*;

    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    t_pk_ctl                 pk_ctl;
    logic [MAX_CODE_LEN-1:0] pk_code;
    logic [LW-1:0]           pk_len;
    logic                    pk_idle;

    chbe_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_take  (pk_idle),
        .o_stall (o_in_stall),
        .o_ctl   (pk_ctl),
        .o_code  (pk_code),
        .o_len   (pk_len)
    );

    chbe_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pk_ctl),
        .i_code      (pk_code),
        .i_len       (pk_len),
        .o_idle      (pk_idle),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the canonical Huffman byte encoder.
`timescale 1ns / 1ps
module testbench;
    import chbe_pkg::*;

    localparam int CODE_MAX = MAX_CODE_LEN_DEF;
    localparam int TABLE_SIZE = SYMBOL_COUNT_DEF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Predicted encoder state: code table, running code, bit buffer
    logic [CODE_MAX-1:0] tbl_code [TABLE_SIZE];
    logic [CLEN_W-1:0]   tbl_len [TABLE_SIZE];
    bit                  tbl_valid [TABLE_SIZE];
    logic [CODE_MAX-1:0] run_code = '0;
    int                  run_len = 0;
    logic [6:0]          buf_bits = '0;
    int                  buf_count = 0;

    t_out_item expected_bytes[$];
    int        error_count = 0;
    int        items_sent = 0;
    bit        src_idle_on = 1'b1;
    bit        sink_idle_on = 1'b1;

    canonical_huffman_byte_encoder u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Update the predicted state for one accepted request and queue its bytes
    task automatic compute_output_bytes(input t_in_item it);
        t_out_item           batch[$];
        t_out_item           r;
        logic [63:0]         widened;
        logic [CODE_MAX-1:0] len_mask;
        logic [7:0]          acc;
        int                  pad;
        case (it.req_type)
            REQ_LOAD: begin
                if (it.sym_len != 0 && it.sym_len <= CODE_MAX && it.sym_len >= run_len) begin
                    widened = {32'b0, run_code} << (it.sym_len - run_len);
                    run_code = widened[CODE_MAX-1:0];
                    len_mask = (it.sym_len >= CODE_MAX) ? '1 : ((32'd1 << it.sym_len) - 1);
                    tbl_code[it.symbol] = run_code & len_mask;
                    tbl_len[it.symbol] = it.sym_len;
                    tbl_valid[it.symbol] = 1'b1;
                    run_code = run_code + 1'b1;
                    run_len = it.sym_len;
                end
            end
            REQ_ENCODE: begin
                if (tbl_valid[it.symbol]) begin
                    // Shift code bits in MSB first, emit each completed byte
                    for (int b = int'(tbl_len[it.symbol]) - 1; b >= 0; b--) begin
                        acc = {buf_bits, tbl_code[it.symbol][b]};
                        buf_count++;
                        if (buf_count == 8) begin
                            r = {acc, KIND_DATA, 1'b0};
                            batch.insert(batch.size(), r);
                            buf_bits = '0;
                            buf_count = 0;
                        end else begin
                            buf_bits = acc[6:0];
                        end
                    end
                end
            end
            REQ_FLUSH: begin
                pad = 8 - buf_count;
                if (buf_count > 0) begin
                    acc = {1'b0, buf_bits} << pad;
                    r = {acc, KIND_DATA, 1'b0};
                    batch.insert(batch.size(), r);
                end
                r = {8'(pad), KIND_PAD, 1'b0};
                batch.insert(batch.size(), r);
                buf_bits = '0;
                buf_count = 0;
            end
            default: begin
                foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
                run_code = '0;
                run_len = 0;
            end
        endcase
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) expected_bytes.insert(expected_bytes.size(), batch[i]);
    endtask

    // Send one request: optional gap, then hold it until the transfer
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                             input logic [CLEN_W-1:0] len);
        t_in_item it;
        int       gap;
        it.req_type = req;
        it.symbol = sym;
        it.sym_len = len;
        gap = src_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        compute_output_bytes(it);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted byte has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Output side: hold stall for a drawn number of cycles after each transfer
    initial begin
        int hold;
        forever begin
            hold = sink_idle_on ? $urandom_range(0, 16) : 0;
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    // Compare each output transfer with the oldest predicted byte
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %h", $time, out_item);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_item.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.out_byte, out_item.out_byte);
                    error_count++;
                end
                if (out_item.byte_kind !== want.byte_kind) begin
                    $display("%0t: byte_kind expected %b actual %b", $time,
                             want.byte_kind, out_item.byte_kind);
                    error_count++;
                end
                if (out_item.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, out_item.last);
                    error_count++;
                end
            end
        end
    end

    // Hand-picked requests: extremes, ignored loads, overfull code, clear with pending bits
    task automatic test_directed_cases();
        send_item(REQ_FLUSH, 8'h00, 6'd0);
        send_item(REQ_LOAD, 8'h00, 6'd0);
        send_item(REQ_LOAD, 8'hFF, 6'd63);
        send_item(REQ_LOAD, 8'hA5, 6'd1);
        send_item(REQ_LOAD, 8'h5A, 6'd1);
        send_item(REQ_LOAD, 8'h10, 6'd1);
        send_item(REQ_LOAD, 8'h3C, 6'd3);
        send_item(REQ_LOAD, 8'h07, 6'd2);
        send_item(REQ_ENCODE, 8'h07, 6'd0);
        send_item(REQ_ENCODE, 8'hA5, 6'd0);
        send_item(REQ_ENCODE, 8'h5A, 6'd0);
        send_item(REQ_ENCODE, 8'h10, 6'd0);
        send_item(REQ_ENCODE, 8'h3C, 6'd63);
        send_item(REQ_LOAD, 8'hFF, 6'd32);
        send_item(REQ_ENCODE, 8'hFF, 6'd0);
        send_item(REQ_LOAD, 8'hA5, 6'd32);
        send_item(REQ_ENCODE, 8'hA5, 6'd0);
        send_item(REQ_FLUSH, 8'hFF, 6'd63);
        send_item(REQ_FLUSH, 8'h00, 6'd0);
        send_item(REQ_ENCODE, 8'h5A, 6'd0);
        send_item(REQ_CLEAR, 8'h00, 6'd0);
        send_item(REQ_LOAD, 8'h00, 6'd8);
        send_item(REQ_ENCODE, 8'h00, 6'd0);
        send_item(REQ_ENCODE, 8'hA5, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 6'd0);
        wait_for_drain();
    endtask

    // One table build, a run of encodes with some noise, then a flush
    task automatic run_session(input int n_encodes);
        logic [SYM_W-1:0] loaded[$];
        int               len;
        int               pick;
        if ($urandom_range(0, 2) != 0) send_item(REQ_CLEAR, SYM_W'($urandom), CLEN_W'($urandom));
        len = $urandom_range(1, 4);
        if (len < run_len) len = run_len;
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(len, CODE_MAX);
            else if ($urandom_range(0, 1) == 1 && len < CODE_MAX) len++;
            loaded.insert(loaded.size(), SYM_W'($urandom));
            send_item(REQ_LOAD, loaded[loaded.size()-1], CLEN_W'(len));
        end
        repeat (n_encodes) begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
                send_item(REQ_ENCODE, loaded[$urandom_range(0, loaded.size()-1)],
                          CLEN_W'($urandom));
            else if (pick < 18)
                send_item(REQ_ENCODE, SYM_W'($urandom), CLEN_W'($urandom));
            else
                send_item(REQ_W'($urandom), SYM_W'($urandom), CLEN_W'($urandom));
        end
        send_item(REQ_FLUSH, SYM_W'($urandom), CLEN_W'($urandom));
    endtask

    task automatic test_random_sessions();
        int target;
        target = items_sent + 70;
        while (items_sent < target) run_session($urandom_range(4, 20));
        wait_for_drain();
    endtask

    // No gaps on either side
    task automatic test_full_rate();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        repeat (2) run_session($urandom_range(8, 20));
        wait_for_drain();
    endtask

    // Input side at full rate against a stalling output side
    task automatic test_output_backpressure();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b1;
        repeat (2) run_session($urandom_range(8, 20));
        wait_for_drain();
    endtask

    initial begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_sessions();
        test_full_rate();
        test_output_backpressure();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Bound the run in case the block hangs
    initial begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
